[sv/tsv_pkg.sv]
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared types, codes and tables for the sample playback voice.
// ----------------------------------------------------------------------------
package tsv_pkg;

    localparam int SAMPLE_DEPTH_DEFAULT  = 65536;
    localparam int FRACTION_BITS_DEFAULT = 16;

    // item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_NOTE   = 2'd1;
    localparam logic [1:0] KIND_VOLUME = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_SAMPLE_LENGTH = 3'd0;
    localparam logic [2:0] CFG_LOOP_BEGIN    = 3'd1;
    localparam logic [2:0] CFG_LOOP_END      = 3'd2;
    localparam logic [2:0] CFG_LOOP_ENABLE   = 3'd3;
    localparam logic [2:0] CFG_C4_SPEED      = 3'd4;
    localparam logic [2:0] CFG_OUTPUT_RATE   = 3'd5;
    localparam logic [2:0] CFG_INST_VOLUME   = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [6:0] MAX_VOLUME   = 7'd64;
    localparam logic [6:0] RESET_VOLUME = 7'd64;
    localparam logic [15:0] RESET_C4    = 16'd8363;
    localparam logic [16:0] RESET_RATE  = 17'd44100;
    localparam logic [6:0] STEP_SCALE   = 7'd107;   // 14317056 / (8363 * 16)
    localparam logic [3:0] PITCH_COUNT  = 4'd12;
    localparam logic [3:0] MAX_OCTAVE   = 4'd7;
    localparam logic [8:0] SAMPLE_BIAS  = 9'd128;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
        logic [7:0]  note_code;
        logic [7:0]  new_volume;
    } in_t;

    typedef struct packed {
        logic signed [13:0] sample_out;
        logic               playing;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_NOTE,
        ST_TICK_RD,
        ST_TICK_EXE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic load_write;
        logic vol_apply;
        logic mul_load;
        logic div_init;
        logic div_step;
        logic note_apply;
        logic tick_read;
        logic tick_update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       pitch_ok;
        logic       div_last;
        logic       play_now;
    } status_t;

    // Amiga-style period for each pitch of the octave
    function automatic logic [10:0] period_lookup(input logic [3:0] pitch);
        logic [10:0] p;
        begin
            case (pitch)
                4'd0:    p = 11'd1712;
                4'd1:    p = 11'd1616;
                4'd2:    p = 11'd1524;
                4'd3:    p = 11'd1440;
                4'd4:    p = 11'd1356;
                4'd5:    p = 11'd1280;
                4'd6:    p = 11'd1208;
                4'd7:    p = 11'd1140;
                4'd8:    p = 11'd1076;
                4'd9:    p = 11'd1016;
                4'd10:   p = 11'd960;
                4'd11:   p = 11'd907;
                default: p = 11'd0;
            endcase
            return p;
        end
    endfunction

endpackage

[sv/tsv_ram.sv]
// ----------------------------------------------------------------------------
// tsv_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

[sv/tsv_ctrl.sv]
// ----------------------------------------------------------------------------
// tsv_ctrl
// Sequencer for the voice: accepts items, steps the datapath, owns the
// result valid flag.
// ----------------------------------------------------------------------------
module tsv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  tsv_pkg::status_t status,
    output tsv_pkg::cmd_t    cmd
);

    tsv_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // hold state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = (state_reg != tsv_pkg::ST_IDLE);
        unique case (state_reg)
            tsv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = tsv_pkg::ST_DECODE;
                end
            end
            tsv_pkg::ST_DECODE:
            begin
                unique case (status.kind)
                    tsv_pkg::KIND_LOAD:
                    begin
                        cmd.load_write = 1'b1;
                        state_next     = tsv_pkg::ST_FINISH;
                    end
                    tsv_pkg::KIND_NOTE:
                    begin
                        cmd.mul_load = 1'b1;
                        state_next   = status.pitch_ok ? tsv_pkg::ST_MUL : tsv_pkg::ST_FINISH;
                    end
                    tsv_pkg::KIND_VOLUME:
                    begin
                        cmd.vol_apply = 1'b1;
                        state_next    = tsv_pkg::ST_FINISH;
                    end
                    default:
                    begin
                        state_next = tsv_pkg::ST_TICK_RD;
                    end
                endcase
            end
            tsv_pkg::ST_MUL:
            begin
                cmd.div_init = 1'b1;
                state_next   = tsv_pkg::ST_DIV;
            end
            tsv_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = tsv_pkg::ST_NOTE;
                end
            end
            tsv_pkg::ST_NOTE:
            begin
                cmd.note_apply = 1'b1;
                state_next     = tsv_pkg::ST_FINISH;
            end
            tsv_pkg::ST_TICK_RD:
            begin
                cmd.tick_read = 1'b1;
                state_next    = status.play_now ? tsv_pkg::ST_TICK_EXE : tsv_pkg::ST_FINISH;
            end
            tsv_pkg::ST_TICK_EXE:
            begin
                cmd.tick_update = 1'b1;
                state_next      = tsv_pkg::ST_FINISH;
            end
            tsv_pkg::ST_FINISH:
            begin
                // wait for the result slot to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = tsv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsv_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/tsv_dp.sv]
// ----------------------------------------------------------------------------
// tsv_dp
// Datapath: configuration registers, voice state, step divider, tick math
// and the result register.
// ----------------------------------------------------------------------------
module tsv_dp #(
    parameter int SAMPLE_DEPTH  = tsv_pkg::SAMPLE_DEPTH_DEFAULT,
    parameter int FRACTION_BITS = tsv_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  tsv_pkg::in_t                    in_data,
    output tsv_pkg::out_t                   out_data,
    input  tsv_pkg::cmd_t                   cmd,
    output tsv_pkg::status_t                status
);

    localparam int AW     = $clog2(SAMPLE_DEPTH);
    localparam int IDX_W  = 33 - FRACTION_BITS;
    localparam int NUM_W  = 23 + FRACTION_BITS;
    localparam int DEN_W  = 28;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int EXT_W  = (NUM_W > 32) ? NUM_W : 33;

    // configuration registers
    logic [16:0] sample_length_reg;
    logic [15:0] loop_begin_reg;
    logic [16:0] loop_end_reg;
    logic        loop_enable_reg;
    logic [15:0] c4_speed_reg;
    logic [16:0] output_rate_reg;
    logic [6:0]  inst_volume_reg;

    // voice state
    logic [31:0] pos_reg, pos_next;
    logic [31:0] step_reg;
    logic [6:0]  vol_reg;
    logic        active_reg;

    tsv_pkg::in_t item_reg;

    // divider
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] acc_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic        tick_play_reg;
    logic signed [13:0] res_sample_reg;
    tsv_pkg::out_t out_reg;

    logic [7:0]  ram_rdata;
    logic [AW-1:0] ram_addr;

    function automatic logic [IDX_W-1:0] round_idx(input logic [31:0] p);
        logic [32:0] s;
        begin
            s = {1'b0, p} + (33'd1 << (FRACTION_BITS - 1));
            return s[32:FRACTION_BITS];
        end
    endfunction

    // decode of the latched item
    logic [3:0]  pitch;
    logic [3:0]  octave;
    logic [10:0] period;
    logic [IDX_W-1:0] idx_now;
    logic        play_now;
    logic [6:0]  vol_clamped;
    logic [6:0]  inst_clamped;

    assign pitch        = item_reg.note_code[3:0];
    assign octave       = (item_reg.note_code[7:4] > tsv_pkg::MAX_OCTAVE)
                          ? tsv_pkg::MAX_OCTAVE : item_reg.note_code[7:4];
    assign period       = tsv_pkg::period_lookup(pitch) >> octave;
    assign idx_now      = round_idx(pos_reg);
    assign play_now     = active_reg && (idx_now < IDX_W'(sample_length_reg));
    assign vol_clamped  = (item_reg.new_volume > 8'(tsv_pkg::MAX_VOLUME))
                          ? tsv_pkg::MAX_VOLUME : item_reg.new_volume[6:0];
    assign inst_clamped = (inst_volume_reg > tsv_pkg::MAX_VOLUME)
                          ? tsv_pkg::MAX_VOLUME : inst_volume_reg;

    // one restoring division step
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             qbit;
    assign rem_sh = {rem_reg, acc_reg[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign qbit   = ~diff[DEN_W+1];

    logic [EXT_W-1:0] quot_ext;
    logic [31:0]      step_sat;
    assign quot_ext = EXT_W'(acc_reg);
    assign step_sat = (|quot_ext[EXT_W-1:32]) ? 32'hFFFF_FFFF : quot_ext[31:0];

    // tick arithmetic
    logic signed [9:0]  centered;
    logic signed [17:0] scaled;
    logic [32:0]        pos_sum;
    logic [31:0]        pos_adv;
    assign centered = $signed({2'b00, ram_rdata}) - $signed({1'b0, tsv_pkg::SAMPLE_BIAS});
    assign scaled   = centered * $signed({1'b0, vol_reg});
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_adv  = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];

    always_comb
    begin
        pos_next = pos_adv;
        if (loop_enable_reg && (round_idx(pos_adv) >= IDX_W'(loop_end_reg)))
        begin
            pos_next = 32'({loop_begin_reg, FRACTION_BITS'(0)});
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_length_reg <= '0;
            loop_begin_reg    <= '0;
            loop_end_reg      <= '0;
            loop_enable_reg   <= 1'b0;
            c4_speed_reg      <= tsv_pkg::RESET_C4;
            output_rate_reg   <= tsv_pkg::RESET_RATE;
            inst_volume_reg   <= tsv_pkg::RESET_VOLUME;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsv_pkg::CFG_SAMPLE_LENGTH: sample_length_reg <= cfg_data;
                tsv_pkg::CFG_LOOP_BEGIN:    loop_begin_reg    <= cfg_data[15:0];
                tsv_pkg::CFG_LOOP_END:      loop_end_reg      <= cfg_data;
                tsv_pkg::CFG_LOOP_ENABLE:   loop_enable_reg   <= cfg_data[0];
                tsv_pkg::CFG_C4_SPEED:      c4_speed_reg      <= cfg_data[15:0];
                tsv_pkg::CFG_OUTPUT_RATE:   output_rate_reg   <= cfg_data;
                tsv_pkg::CFG_INST_VOLUME:   inst_volume_reg   <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // voice state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            step_reg   <= '0;
            vol_reg    <= tsv_pkg::RESET_VOLUME;
            active_reg <= 1'b0;
        end
        else
        begin
            if (cmd.vol_apply)
            begin
                vol_reg <= vol_clamped;
            end
            if (cmd.note_apply)
            begin
                step_reg   <= step_sat;
                vol_reg    <= inst_clamped;
                pos_reg    <= '0;
                active_reg <= 1'b1;
            end
            if (cmd.tick_update)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // item latch, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            item_reg       <= in_data;
            res_sample_reg <= '0;
            tick_play_reg  <= 1'b0;
        end
        if (cmd.mul_load)
        begin
            den_reg <= DEN_W'(period * output_rate_reg);
            acc_reg <= NUM_W'({23'(tsv_pkg::STEP_SCALE) * 23'(c4_speed_reg),
                               FRACTION_BITS'(0)});
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            acc_reg <= {acc_reg[NUM_W-2:0], qbit};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.tick_read)
        begin
            tick_play_reg <= play_now;
        end
        if (cmd.tick_update)
        begin
            res_sample_reg <= scaled[13:0];
        end
        if (cmd.out_load)
        begin
            out_reg.sample_out <= res_sample_reg;
            out_reg.playing    <= (item_reg.kind == tsv_pkg::KIND_TICK) ? tick_play_reg
                                                                        : play_now;
        end
    end

    // sample memory
    assign ram_addr = cmd.load_write ? item_reg.load_address[AW-1:0] : idx_now[AW-1:0];

    tsv_ram #(
        .WIDTH (8),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (cmd.load_write),
        .addr  (ram_addr),
        .wdata (item_reg.load_byte),
        .rdata (ram_rdata)
    );

    assign status.kind     = item_reg.kind;
    assign status.pitch_ok = (pitch < tsv_pkg::PITCH_COUNT);
    assign status.div_last = (cnt_reg == CNT_W'(NUM_W - 1));
    assign status.play_now = play_now;
    assign out_data        = out_reg;

endmodule

[sv/tracker_sample_voice.sv]
// ----------------------------------------------------------------------------
// tracker_sample_voice
// One wavetable voice: sample memory loads, note-on step computation,
// volume control and per-tick sample output.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  in       | in_valid / in_stall  | in_data  (tsv_pkg::in_t)
//  out      | out_valid / out_stall| out_data (tsv_pkg::out_t)
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  One item at a time. Load and volume pass decode and finish; a tick adds a
//  read and, while playing, an update state; a note-on adds the multiply, the
//  bit-serial step divider and the note state, skipped for a bad pitch.
//  Reset clears control state and returns configuration to its defaults;
//  sample memory is undefined until written. A stalled result holds in the
//  output register while the next item is accepted; that item waits at its
//  end for the slot.
// ----------------------------------------------------------------------------
module tracker_sample_voice #(
    parameter int SAMPLE_DEPTH  = tsv_pkg::SAMPLE_DEPTH_DEFAULT,
    parameter int FRACTION_BITS = tsv_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  tsv_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output tsv_pkg::out_t                   out_data,
    input  logic                            cfg_we,
    input  logic [tsv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tsv_pkg::cmd_t    cmd;
    tsv_pkg::status_t status;

    tsv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tsv_dp #(
        .SAMPLE_DEPTH  (SAMPLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[bench/tb_tracker_sample_voice.sv]
// ----------------------------------------------------------------------------
// tb_tracker_sample_voice
// Self-checking bench for the sample playback voice. A scoreboard class
// predicts every result from its own copy of the voice state; tasks drive
// loads, note-ons, volume changes and ticks under random gaps and stalls,
// and reprogram the registers between phases while the voice is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tracker_sample_voice;

    localparam int  PHASES       = 12;
    localparam int  PHASE_ITEMS  = 150;
    localparam int  SETTLE       = 60;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  CYCLE_LIMIT  = 1500000;
    localparam int  IN_W         = $bits(tsv_pkg::in_t);

    // ------------------------------------------------------------------------
    // Voice predictor and expected result store
    // ------------------------------------------------------------------------
    class voice_scoreboard;
        logic [16:0] smp_len, lp_end, rate;
        logic [15:0] lp_beg, c4;
        logic        lp_en;
        logic [6:0]  ivol;
        bit [7:0]    mem [int];
        logic [31:0] pos, step;
        logic [6:0]  vol;
        bit          active;
        tsv_pkg::out_t expected_q[$];
        int          errors;

        function new();
            smp_len = 0; lp_beg = 0; lp_end = 0; lp_en = 0;
            c4 = 16'd8363; rate = 17'd44100; ivol = 7'd64;
            pos = 0; step = 0; vol = 7'd64; active = 0; errors = 0;
        endfunction

        function logic [16:0] round_idx(logic [31:0] p);
            logic [32:0] t;
            t = {1'b0, p} + 33'd32768;
            return t[32:16];
        endfunction

        function logic [10:0] period_of(logic [3:0] pitch);
            logic [10:0] tbl [12];
            tbl = '{11'd1712, 11'd1616, 11'd1524, 11'd1440, 11'd1356, 11'd1280,
                    11'd1208, 11'd1140, 11'd1076, 11'd1016, 11'd960, 11'd907};
            return tbl[pitch];
        endfunction

        function void write_reg(logic [2:0] idx, logic [16:0] d);
            case (idx)
                tsv_pkg::CFG_SAMPLE_LENGTH: smp_len = d;
                tsv_pkg::CFG_LOOP_BEGIN:    lp_beg  = d[15:0];
                tsv_pkg::CFG_LOOP_END:      lp_end  = d;
                tsv_pkg::CFG_LOOP_ENABLE:   lp_en   = d[0];
                tsv_pkg::CFG_C4_SPEED:      c4      = d[15:0];
                tsv_pkg::CFG_OUTPUT_RATE:   rate    = d;
                tsv_pkg::CFG_INST_VOLUME:   ivol    = d[6:0];
                default: ;
            endcase
        endfunction

        // address a tick would read without it being loaded, or -1
        function int missing_addr(tsv_pkg::in_t x);
            logic [16:0] idx;
            idx = round_idx(pos);
            if (x.kind == tsv_pkg::KIND_TICK && active && idx < smp_len
                && !mem.exists(int'(idx[15:0])))
                return int'(idx[15:0]);
            return -1;
        endfunction

        // advance the voice by one accepted transfer and queue its result
        function void note(tsv_pkg::in_t x);
            tsv_pkg::out_t r;
            logic [3:0]  pitch, oct;
            logic [63:0] den, num, q;
            logic [16:0] idx;
            logic [32:0] nxt;
            int          val;
            r = '0;
            case (x.kind)
                tsv_pkg::KIND_LOAD: mem[int'(x.load_address)] = x.load_byte;
                tsv_pkg::KIND_NOTE:
                begin
                    pitch = x.note_code[3:0];
                    oct   = x.note_code[7:4];
                    if (pitch < 12)
                    begin
                        if (oct > 7) oct = 7;
                        den = 64'(period_of(pitch) >> oct) * 64'(rate);
                        num = (64'd107 * 64'(c4)) << 16;
                        if (den == 0) q = 64'hFFFF_FFFF;
                        else
                        begin
                            q = num / den;
                            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
                        end
                        step   = q[31:0];
                        vol    = (ivol > 64) ? 7'd64 : ivol;
                        pos    = 0;
                        active = 1;
                    end
                end
                tsv_pkg::KIND_VOLUME:
                    vol = (x.new_volume > 64) ? 7'd64 : x.new_volume[6:0];
                default: ;
            endcase
            if (x.kind == tsv_pkg::KIND_TICK)
            begin
                idx = round_idx(pos);
                r.playing = active && idx < smp_len;
                if (r.playing)
                begin
                    val = (int'(mem[int'(idx[15:0])]) - 128) * int'(vol);
                    nxt = {1'b0, pos} + {1'b0, step};
                    pos = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
                    if (lp_en && round_idx(pos) >= lp_end) pos = {lp_beg, 16'h0};
                    r.sample_out = val[13:0];
                end
            end
            else
                r.playing = active && round_idx(pos) < smp_len;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(tsv_pkg::out_t y);
            tsv_pkg::out_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result %0d/%0b", y.sample_out, y.playing));
                return;
            end
            e = expected_q.pop_front();
            if (y.sample_out !== e.sample_out)
                report($sformatf("sample_out %0d, want %0d", y.sample_out, e.sample_out));
            if (y.playing !== e.playing)
                report($sformatf("playing %0b, want %0b", y.playing, e.playing));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    tsv_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_stall;
    tsv_pkg::out_t out_data;
    logic          cfg_we;
    logic [tsv_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tsv_pkg::CFG_DATA_W-1:0]  cfg_data;

    voice_scoreboard sb;
    int  cycles;
    bit  hold_req;
    bit  no_gaps;
    int  hold_left, stall_left, free_left;

    tracker_sample_voice dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check(out_data);
    end

    // receiver stalls: random bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        int r;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 8)       stall_left = $urandom_range(20, 60);
            else if (r < 40) stall_left = $urandom_range(1, 3);
            else if (r < 50) free_left  = $urandom_range(50, 200);
            else             free_left  = $urandom_range(1, 20);
            out_stall <= 1'b0;
        end
    end

    // hold one transfer until accepted
    task automatic drive(tsv_pkg::in_t x);
        in_valid <= 1'b1;
        in_data  <= x;
        do @(posedge clk); while (in_stall);
        sb.note(x);
    endtask

    // offer an item; load any sample byte a tick would need first
    task automatic offer(tsv_pkg::in_t x);
        tsv_pkg::in_t ld;
        int  a, g, r;
        a = sb.missing_addr(x);
        while (a >= 0)
        begin
            ld = tsv_pkg::in_t'(IN_W'({$urandom, $urandom}));
            ld.kind = tsv_pkg::KIND_LOAD;
            ld.load_address = a[15:0];
            drive(ld);
            a = sb.missing_addr(x);
        end
        drive(x);
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) g = 0;
        else if (r < 92)       g = $urandom_range(1, 3);
        else                   g = $urandom_range(10, 40);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic offer_fields(logic [1:0] k, logic [15:0] a, logic [7:0] b,
                                logic [7:0] n, logic [7:0] v);
        tsv_pkg::in_t x;
        x.kind = k; x.load_address = a; x.load_byte = b; x.note_code = n; x.new_volume = v;
        offer(x);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [16:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
    endtask

    // reprogram every register while idle
    task automatic program_voice(logic [16:0] len, logic [15:0] lb, logic [16:0] le,
                                 logic en, logic [15:0] c, logic [16:0] rt, logic [6:0] iv);
        drain();
        repeat (SETTLE) @(posedge clk);
        write_cfg(tsv_pkg::CFG_SAMPLE_LENGTH, len);
        write_cfg(tsv_pkg::CFG_LOOP_BEGIN, {1'b0, lb});
        write_cfg(tsv_pkg::CFG_LOOP_END, le);
        write_cfg(tsv_pkg::CFG_LOOP_ENABLE, {16'h0, en});
        write_cfg(tsv_pkg::CFG_C4_SPEED, {1'b0, c});
        write_cfg(tsv_pkg::CFG_OUTPUT_RATE, rt);
        write_cfg(tsv_pkg::CFG_INST_VOLUME, {10'h0, iv});
        cfg_we <= 1'b0;
    endtask

    task automatic program_random();
        logic [16:0] len, le;
        logic [15:0] lb;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      len = 17'($urandom_range(1, 300));
        else if (r < 70) len = 17'd65536;
        else if (r < 75) len = 17'h1FFFF;
        else if (r < 80) len = 0;
        else             len = 17'($urandom_range(0, 17'h1FFFF));
        lb = (len > 1 && $urandom_range(0, 3) != 0) ? 16'($urandom_range(0, len - 1))
                                                     : 16'($urandom);
        le = ($urandom_range(0, 3) != 0) ? 17'($urandom_range(0, len))
                                         : 17'($urandom_range(0, 17'h1FFFF));
        program_voice(len, lb, le, 1'($urandom), 16'($urandom_range(1, 65535)),
                      17'(($urandom_range(0, 9) == 0) ? $urandom
                                                       : $urandom_range(1000, 96000)),
                      7'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 64)));
    endtask

    // random item: mostly ticks, with loads, note-ons and volume changes
    function automatic tsv_pkg::in_t pick_item();
        tsv_pkg::in_t x;
        int  r;
        x = tsv_pkg::in_t'(IN_W'({$urandom, $urandom}));
        r = $urandom_range(0, 99);
        if (r < 55)      x.kind = tsv_pkg::KIND_TICK;
        else if (r < 75) x.kind = tsv_pkg::KIND_LOAD;
        else if (r < 87) x.kind = tsv_pkg::KIND_NOTE;
        else             x.kind = tsv_pkg::KIND_VOLUME;
        if ($urandom_range(0, 1) == 0) x.load_address = 16'($urandom_range(0, 255));
        if ($urandom_range(0, 6) != 0)
            x.note_code = {x.note_code[7:4], 4'($urandom_range(0, 11))};
        if ($urandom_range(0, 2) != 0) x.new_volume = 8'($urandom_range(0, 64));
        return x;
    endfunction

    initial
    begin
        sb        = new();
        cycles    = 0;
        hold_req  = 0;
        no_gaps   = 0;
        hold_left = 0; stall_left = 0; free_left = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: nothing plays yet
        offer_fields(tsv_pkg::KIND_TICK, 16'h0, 8'h0, 8'h00, 8'h0);
        offer_fields(tsv_pkg::KIND_NOTE, 16'h0, 8'h0, 8'h00, 8'h0);
        offer_fields(tsv_pkg::KIND_TICK, 16'h0, 8'h0, 8'h00, 8'h0);
        offer_fields(tsv_pkg::KIND_VOLUME, 16'h0, 8'h0, 8'h00, 8'd200);

        // directed: byte extremes, octave and pitch limits, volume clamps
        program_voice(17'd32, 16'd0, 17'd0, 1'b0, 16'd8363, 17'd44100, 7'd64);
        offer_fields(tsv_pkg::KIND_LOAD, 16'd0, 8'd0, 8'h00, 8'h0);
        offer_fields(tsv_pkg::KIND_LOAD, 16'd1, 8'd255, 8'h00, 8'h0);
        offer_fields(tsv_pkg::KIND_LOAD, 16'd2, 8'd128, 8'h00, 8'h0);
        offer_fields(tsv_pkg::KIND_LOAD, 16'hFFFF, 8'd255, 8'hFF, 8'hFF);
        offer_fields(tsv_pkg::KIND_NOTE, 16'h0, 8'h0, 8'h70, 8'h0);
        repeat (3) offer_fields(tsv_pkg::KIND_TICK, 16'h0, 8'h0, 8'h0, 8'h0);
        offer_fields(tsv_pkg::KIND_NOTE, 16'h0, 8'h0, 8'hFB, 8'h0);
        offer_fields(tsv_pkg::KIND_VOLUME, 16'h0, 8'h0, 8'h0, 8'd0);
        offer_fields(tsv_pkg::KIND_TICK, 16'h0, 8'h0, 8'h0, 8'h0);
        offer_fields(tsv_pkg::KIND_VOLUME, 16'h0, 8'h0, 8'h0, 8'd64);
        offer_fields(tsv_pkg::KIND_VOLUME, 16'h0, 8'h0, 8'h0, 8'd65);
        offer_fields(tsv_pkg::KIND_TICK, 16'h0, 8'h0, 8'h0, 8'h0);
        offer_fields(tsv_pkg::KIND_NOTE, 16'h0, 8'h0, 8'h0C, 8'h0);
        offer_fields(tsv_pkg::KIND_NOTE, 16'h0, 8'h0, 8'h0F, 8'h0);
        offer_fields(tsv_pkg::KIND_TICK, 16'h0, 8'h0, 8'h0, 8'h0);
        offer_fields(tsv_pkg::KIND_NOTE, 16'h0, 8'h0, 8'h00, 8'h0);
        repeat (2) offer_fields(tsv_pkg::KIND_TICK, 16'h0, 8'h0, 8'h0, 8'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                2: program_voice(17'd65536, 16'hFFFF, 17'd65536, 1'b1, 16'hFFFF,
                                 17'd1000, 7'd127);
                3: program_voice(17'd0, 16'd0, 17'd0, 1'b0, 16'd0, 17'd0, 7'd0);
                4: program_voice(17'd200, 16'd10, 17'd0, 1'b1, 16'd1, 17'h1FFFF, 7'd64);
                7: program_voice(17'd64, 16'd8, 17'd40, 1'b1, 16'd8363, 17'd0, 7'd65);
                default: program_random();
            endcase
            no_gaps = (p % 4 == 1);
            if (p == 5) hold_req = 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 6 && i == PHASE_ITEMS / 2) drain();
                offer(pick_item());
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
